// ===== src/pbc_pkg.sv =====
// Shared types, constants and CRC functions for the pak block CRC checker.
package pbc_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_ADDR    = 2'd0,
      KIND_CRC     = 2'd1,
      KIND_VERDICT = 2'd2
   } kind_type;

   // Request action codes
   typedef enum logic {
      ACT_ADDRESS = 1'b0,
      ACT_DATA    = 1'b1
   } action_type;

   localparam logic [7:0]  CRC_POLY       = 8'h85;
   localparam logic [15:0] ADDR_BASE_MASK = 16'hFFE0;
   localparam int          ADDR_LOW_BITS  = 5;

   // Per-bit contributions to the 5-bit address CRC, indexed by address bit
   localparam logic [4:0] ADDR_XOR [16] = '{
      5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h15, 5'h1F, 5'h0B,
      5'h16, 5'h19, 5'h07, 5'h0E, 5'h1C, 5'h0D, 5'h1A, 5'h01
   };

   // Replace low address bits with the address CRC
   function automatic logic [15:0] code_address(input logic [15:0] addr);
      logic [4:0] crc;
      crc = '0;
      for (int b = ADDR_LOW_BITS; b < 16; b++) begin
         if (addr[b]) begin
            crc = crc ^ ADDR_XOR[b];
         end
      end
      return (addr & ADDR_BASE_MASK) | {11'd0, crc};
   endfunction

   // Shift one byte MSB first into the CRC-8 register
   function automatic logic [7:0] crc_shift_byte(input logic [7:0] crc,
                                                 input logic [7:0] din);
      logic [7:0] c;
      logic       msb;
      c = crc;
      for (int j = 7; j >= 0; j--) begin
         msb = c[7];
         c   = {c[6:0], din[j]} ^ (msb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

endpackage

// ===== src/pbc_channels.sv =====
// Request and response stream interfaces for the pak block CRC checker.
interface pbc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] address;
   logic [7:0]  data_byte;

   modport source (output valid, output action, output address, output data_byte,
                   input ready);
   modport sink   (input valid, input action, input address, input data_byte,
                   output ready);
endinterface

interface pbc_rsp_if;
   logic              valid;
   logic              ready;
   pbc_pkg::kind_type kind;
   logic [15:0]       coded_address;
   logic [7:0]        crc_value;
   logic              crc_ok;

   modport source (output valid, output kind, output coded_address, output crc_value,
                   output crc_ok, input ready);
   modport sink   (input valid, input kind, input coded_address, input crc_value,
                   input crc_ok, output ready);
endinterface

// ===== src/pak_block_crc_checker_core.sv =====
// Pak block CRC checker: address coding, CRC-8 over a data block, CRC check.
// Responses come from an output register, valid in the cycle after request accept.
// Throughput: one request per cycle; the single CRC-8 byte update plus the
//   zero-byte augmentation path sets the cycle, stalls only on rsp backpressure.
// Reset (synchronous, active high): byte counter idle (BLOCK_BYTES+1), CRC
//   and final CRC cleared, response register empty.
module pak_block_crc_checker_core #(
   parameter int BLOCK_BYTES = 32
) (
   input logic      clock,
   input logic      reset,
   pbc_req_if.sink  req_chan,
   pbc_rsp_if.source rsp_chan
);
   import pbc_pkg::*;

   // Counter holds 0..BLOCK_BYTES+1; the top value means idle until an address
   localparam int CNT_W = $clog2(BLOCK_BYTES + 2);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(BLOCK_BYTES - 1);
   localparam logic [CNT_W-1:0] CNT_CHECK = CNT_W'(BLOCK_BYTES);
   localparam logic [CNT_W-1:0] CNT_IDLE  = CNT_W'(BLOCK_BYTES + 1);

   // Block state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       final_ff, final_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         kind_ff, kind_in;
   logic [15:0]      coded_ff, coded_in;
   logic [7:0]       crc_value_ff, crc_value_in;
   logic             crc_ok_ff, crc_ok_in;

   logic             req_accept;
   logic             emit;
   logic [7:0]       crc_next;
   logic [7:0]       crc_aug;

   // Request is taken whenever the output slot is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Byte update and zero-byte augmentation for the last data byte
   assign crc_next = crc_shift_byte(crc_ff, req_chan.data_byte);
   assign crc_aug  = crc_shift_byte(crc_next, 8'h00);

   always_comb begin
      count_in     = count_ff;
      crc_in       = crc_ff;
      final_in     = final_ff;
      emit         = 1'b0;
      kind_in      = kind_ff;
      coded_in     = coded_ff;
      crc_value_in = crc_value_ff;
      crc_ok_in    = crc_ok_ff;
      if (req_accept) begin
         priority if (req_chan.action == ACT_ADDRESS) begin
            // address always restarts the block
            crc_in       = 8'h00;
            count_in     = '0;
            emit         = 1'b1;
            kind_in      = KIND_ADDR;
            coded_in     = code_address(req_chan.address);
            crc_value_in = 8'h00;
            crc_ok_in    = 1'b0;
         end else if (count_ff < CNT_CHECK) begin
            crc_in   = crc_next;
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_LAST) begin
               final_in     = crc_aug;
               emit         = 1'b1;
               kind_in      = KIND_CRC;
               coded_in     = 16'h0000;
               crc_value_in = crc_aug;
               crc_ok_in    = 1'b0;
            end
         end else if (count_ff == CNT_CHECK) begin
            // received CRC byte: verdict, then idle
            count_in     = CNT_IDLE;
            emit         = 1'b1;
            kind_in      = KIND_VERDICT;
            coded_in     = 16'h0000;
            crc_value_in = final_ff;
            crc_ok_in    = (req_chan.data_byte == final_ff);
         end else begin
            // data while idle is dropped
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_IDLE;
         crc_ff       <= 8'h00;
         final_ff     <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds while the slot is full and stalled
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      coded_ff     <= coded_in;
      crc_value_ff <= crc_value_in;
      crc_ok_ff    <= crc_ok_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = kind_ff;
   assign rsp_chan.coded_address = coded_ff;
   assign rsp_chan.crc_value     = crc_value_ff;
   assign rsp_chan.crc_ok        = crc_ok_ff;

   // Counter never passes the idle value
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_IDLE)
      else $error("byte counter out of range");

   // An accepted address yields a coded-address response next cycle
   a_addr_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.action == ACT_ADDRESS) |=>
         (rsp_valid_ff && kind_ff == KIND_ADDR && count_ff == '0))
      else $error("address request without coded-address response");

   // Verdict reports the stored final CRC and leaves the block idle
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_VERDICT && $changed(rsp_valid_ff)) |->
         (crc_value_ff == final_ff && count_ff == CNT_IDLE))
      else $error("verdict inconsistent with final CRC");

   // Pass flag only ever set on a verdict
   a_ok_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && crc_ok_ff) |-> (kind_ff == KIND_VERDICT))
      else $error("crc_ok set on non-verdict response");

endmodule

// ===== sim/testbench.sv =====
// Testbench for the pak block CRC checker: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module testbench;
   import pbc_pkg::*;

   localparam int         BLOCK_LEN     = 32;       // data bytes per block
   localparam logic [7:0] CRC8_POLY     = 8'h85;
   localparam int         RANDOM_ITEMS  = 400;      // random requests to aim for
   localparam int         STALL_LIMIT   = 1000;     // cycles without any handshake
   localparam int         TAIL_CYCLES   = 8;        // settle time once all results are in

   // One expected or observed response
   typedef struct packed {
      kind_type    kind;
      logic [15:0] coded_address;
      logic [7:0]  crc_value;
      logic        crc_ok;
   } pak_result_type;

   logic clock;
   logic reset;

   pbc_req_if req_bus ();
   pbc_rsp_if rsp_bus ();

   pak_block_crc_checker_core #(
      .BLOCK_BYTES (BLOCK_LEN)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 4 ns period
   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: mirrors the block's CRC register, byte counter and
   // the augmented CRC of the last completed block.
   // ---------------------------------------------------------------------
   logic [7:0]  blk_crc;
   int          blk_count;
   logic [7:0]  blk_final;

   pak_result_type pending_results [$];   // responses still owed by the block

   int requests_sent;
   int random_requests;
   int burst_left;
   int error_count;
   int idle_cycles;
   int seen_addresses;
   int seen_crcs;
   int seen_good_verdicts;
   int seen_bad_verdicts;

   // Address CRC contribution of each address bit; bits 4..0 give nothing
   function automatic logic [4:0] addr_bit_word(input int b);
      case (b)
         5:       return 5'h15;
         6:       return 5'h1F;
         7:       return 5'h0B;
         8:       return 5'h16;
         9:       return 5'h19;
         10:      return 5'h07;
         11:      return 5'h0E;
         12:      return 5'h1C;
         13:      return 5'h0D;
         14:      return 5'h1A;
         15:      return 5'h01;
         default: return 5'h00;
      endcase
   endfunction

   function automatic logic [15:0] expected_coded_address(input logic [15:0] a);
      logic [4:0] c;
      c = '0;
      for (int b = 15; b >= 5; b--) begin
         if (a[b]) c = c ^ addr_bit_word(b);
      end
      return {a[15:5], c};
   endfunction

   // MSB-first CRC-8 update, one bit per pass
   function automatic logic [7:0] crc8_after_byte(input logic [7:0] crc,
                                                  input logic [7:0] d);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int j = 7; j >= 0; j--) begin
         fb = c[7];
         c  = {c[6:0], d[j]};
         if (fb) c = c ^ CRC8_POLY;
      end
      return c;
   endfunction

   // Advance the predictor by one accepted request and queue what it owes
   task automatic predict_request(input action_type act, input logic [15:0] addr,
                                  input logic [7:0] dbyte);
      pak_result_type r;
      r = '{kind: KIND_ADDR, coded_address: 16'h0, crc_value: 8'h0, crc_ok: 1'b0};
      if (act == ACT_ADDRESS) begin
         // address always restarts the block, partial data is dropped
         blk_crc         = '0;
         blk_count       = 0;
         r.coded_address = expected_coded_address(addr);
         pending_results.push_back(r);
      end else if (blk_count < BLOCK_LEN) begin
         blk_crc   = crc8_after_byte(blk_crc, dbyte);
         blk_count = blk_count + 1;
         if (blk_count == BLOCK_LEN) begin
            // augment with eight zero bits
            blk_final   = crc8_after_byte(blk_crc, 8'h00);
            r.kind      = KIND_CRC;
            r.crc_value = blk_final;
            pending_results.push_back(r);
         end
      end else if (blk_count == BLOCK_LEN) begin
         // byte after the block is the received CRC
         blk_count   = BLOCK_LEN + 1;
         r.kind      = KIND_VERDICT;
         r.crc_value = blk_final;
         r.crc_ok    = (dbyte == blk_final);
         pending_results.push_back(r);
      end
      // otherwise idle: byte dropped, nothing owed
   endtask

   // ---------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps, or none. valid is
   // only ever lowered at a falling edge where no request follows.
   // ---------------------------------------------------------------------
   task automatic send_request(input action_type act, input logic [15:0] addr,
                               input logic [7:0] dbyte);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.address   <= addr;
      req_bus.data_byte <= dbyte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_request(act, addr, dbyte);
      requests_sent = requests_sent + 1;
   endtask

   // Drop valid and hold off until every owed response has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: ready follows a pattern that cycles through always ready,
   // coin flip, one in four, and mostly ready.
   // ---------------------------------------------------------------------
   int rx_cycle;

   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[8:7])
         2'd0:    rsp_bus.ready <= 1'b1;
         2'd1:    rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         2'd2:    rsp_bus.ready <= (rx_cycle[1:0] == 2'd0);
         default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // ---------------------------------------------------------------------
   // Response checker: each accepted response against the oldest one owed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pak_result_type got;
      pak_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{kind: rsp_bus.kind, coded_address: rsp_bus.coded_address,
                 crc_value: rsp_bus.crc_value, crc_ok: rsp_bus.crc_ok};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, kind %0d addr %h crc %h ok %b",
                     $time, got.kind, got.coded_address, got.crc_value, got.crc_ok);
            error_count = error_count + 1;
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
               $display("%0t: kind mismatch, expected %0d, actual %0d",
                        $time, want.kind, got.kind);
               error_count = error_count + 1;
            end
            if (got.coded_address !== want.coded_address) begin
               $display("%0t: coded_address mismatch, expected %h, actual %h",
                        $time, want.coded_address, got.coded_address);
               error_count = error_count + 1;
            end
            if (got.crc_value !== want.crc_value) begin
               $display("%0t: crc_value mismatch, expected %h, actual %h",
                        $time, want.crc_value, got.crc_value);
               error_count = error_count + 1;
            end
            if (got.crc_ok !== want.crc_ok) begin
               $display("%0t: crc_ok mismatch, expected %b, actual %b",
                        $time, want.crc_ok, got.crc_ok);
               error_count = error_count + 1;
            end
            case (want.kind)
               KIND_ADDR: seen_addresses = seen_addresses + 1;
               KIND_CRC:  seen_crcs = seen_crcs + 1;
               default: begin
                  if (want.crc_ok) seen_good_verdicts = seen_good_verdicts + 1;
                  else             seen_bad_verdicts = seen_bad_verdicts + 1;
               end
            endcase
         end
      end
   end

   // Watchdog: cycles in which neither channel completes a handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("%0t: no handshake for %0d cycles, %0d responses still owed",
               $time, STALL_LIMIT, pending_results.size());
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Data bytes before any address are dropped without a response
   task automatic test_idle_data();
      send_request(ACT_DATA, 16'h0000, 8'h00);
      send_request(ACT_DATA, 16'hFFFF, 8'hFF);
   endtask

   // Address coding at the extremes; low five bits must be ignored
   task automatic test_address_coding();
      send_request(ACT_ADDRESS, 16'h0000, 8'h00);
      send_request(ACT_ADDRESS, 16'hFFFF, 8'hFF);
      send_request(ACT_ADDRESS, 16'h001F, 8'h00);
      send_request(ACT_ADDRESS, 16'hFFE0, 8'h00);
      send_request(ACT_ADDRESS, 16'h8000, 8'h00);
      send_request(ACT_ADDRESS, 16'h0020, 8'h00);
      send_request(ACT_ADDRESS, 16'hAAAA, 8'h00);
      send_request(ACT_ADDRESS, 16'h5555, 8'h00);
   endtask

   // Address mid-block restarts; the partial block leaves no trace
   task automatic test_abandoned_block();
      send_request(ACT_ADDRESS, 16'h1234, 8'h00);
      for (int i = 0; i < 5; i++) send_request(ACT_DATA, 16'h0000, 8'hA5 ^ i[7:0]);
      send_request(ACT_ADDRESS, 16'h4321, 8'h00);
      send_request(ACT_DATA, 16'h0000, 8'hFF);
   endtask

   // Half a block, a full pause until the address response is back, then the rest
   task automatic test_drain_pause();
      send_request(ACT_ADDRESS, 16'($urandom), 8'h00);
      for (int i = 0; i < BLOCK_LEN / 2; i++)
         send_request(ACT_DATA, 16'h0000, 8'($urandom_range(0, 255)));
      wait_for_drain();
      for (int i = BLOCK_LEN / 2; i < BLOCK_LEN; i++)
         send_request(ACT_DATA, 16'h0000, 8'($urandom_range(0, 255)));
      send_request(ACT_DATA, 16'h0000, blk_final);
   endtask

   // Mostly whole blocks with patterned or random content, plus broken blocks and noise
   task automatic test_random_blocks();
      int          pick;
      int          style;
      int          n;
      logic [7:0]  b;
      logic [15:0] a;
      int          start;
      while (random_requests < RANDOM_ITEMS) begin
         start = requests_sent;
         pick  = $urandom_range(0, 9);
         a     = 16'($urandom);
         if (pick <= 6) begin
            // well-formed block: address, data, received CRC, maybe trailing bytes
            style = $urandom_range(0, 5);
            send_request(ACT_ADDRESS, a, 8'($urandom_range(0, 255)));
            for (int i = 0; i < BLOCK_LEN; i++) begin
               case (style)
                  0:       b = 8'h00;
                  1:       b = 8'hFF;
                  2:       b = 8'(i);
                  default: b = 8'($urandom_range(0, 255));
               endcase
               send_request(ACT_DATA, 16'($urandom), b);
            end
            // half the time a matching CRC byte, else a random one
            b = ($urandom_range(0, 1) == 1) ? blk_final : 8'($urandom_range(0, 255));
            send_request(ACT_DATA, 16'($urandom), b);
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
               send_request(ACT_DATA, 16'($urandom), 8'($urandom_range(0, 255)));
         end else if (pick == 7) begin
            // block cut short, with fewer than BLOCK_LEN data bytes
            send_request(ACT_ADDRESS, a, 8'h00);
            n = $urandom_range(0, BLOCK_LEN - 1);
            for (int i = 0; i < n; i++)
               send_request(ACT_DATA, 16'($urandom), 8'($urandom_range(0, 255)));
         end else if (pick == 8) begin
            // stray data bytes
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               send_request(ACT_DATA, 16'($urandom), 8'($urandom_range(0, 255)));
         end else begin
            // back-to-back addresses
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               send_request(ACT_ADDRESS, 16'($urandom), 8'($urandom_range(0, 255)));
         end
         random_requests = random_requests + (requests_sent - start);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_ADDRESS;
      req_bus.address    = 16'h0000;
      req_bus.data_byte  = 8'h00;
      blk_crc            = '0;
      blk_count          = BLOCK_LEN + 1;   // idle until an address arrives
      blk_final          = '0;
      requests_sent      = 0;
      random_requests    = 0;
      burst_left         = 0;
      error_count        = 0;
      seen_addresses     = 0;
      seen_crcs          = 0;
      seen_good_verdicts = 0;
      seen_bad_verdicts  = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_data();
      test_address_coding();
      test_abandoned_block();
      test_drain_pause();
      test_random_blocks();

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d random); checked %0d address codings, %0d block CRCs,",
               requests_sent, random_requests, seen_addresses, seen_crcs);
      $display("and %0d verdicts (%0d matching, %0d mismatching).",
               seen_good_verdicts + seen_bad_verdicts, seen_good_verdicts, seen_bad_verdicts);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
